@@ design/vnf_pkg.sv @@
// Shared types, constants and the micro-program of the fractal value noise sampler.
`timescale 1ns / 1ps
package vnf_pkg;

  // Field widths
  localparam int SEED_W   = 32;
  localparam int WORLD_W  = 48;
  localparam int HEIGHT_W = 25;
  localparam int CFG_W    = 5;

  // Noise configuration
  localparam int OCTAVES    = 4;
  localparam int MAX_LAYERS = 16;
  localparam int LAYERS_RST = 4;
  localparam int OCT_W      = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;

  // Fixed-point constants (Q.24)
  localparam logic [63:0] QONE       = 64'd1 << 24;
  localparam logic [63:0] LIMIT      = 64'd1 << 54;
  localparam logic [63:0] SCALE_STEP = 64'd6207570;
  localparam logic [63:0] ROT_C      = 64'd9473001;
  localparam logic [63:0] ROT_S      = 64'd13846921;
  localparam logic [31:0] SALT_BASE  = 32'h9E3779B9;
  localparam logic [31:0] SALT_STEP  = 32'h85EBCA6B;
  localparam logic [63:0] OCT_MASK   = (64'd1 << OCTAVES) - 64'd1;

  // Divider sizing: sum < layers * (2^OCTAVES - 1) * 2^24
  localparam int SUM_W   = CFG_W + OCTAVES + 24;
  localparam int DVD_W   = SUM_W + 9;
  localparam int DVS_W   = CFG_W + OCTAVES + 8;
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int HSCALE  = 400;

  // Register file
  localparam int RF_AW = 4;
  localparam int RF_N  = 1 << RF_AW;
  localparam logic [RF_AW-1:0] R_BX   = 4'd0;
  localparam logic [RF_AW-1:0] R_BY   = 4'd1;
  localparam logic [RF_AW-1:0] R_X    = 4'd2;
  localparam logic [RF_AW-1:0] R_Y    = 4'd3;
  localparam logic [RF_AW-1:0] R_SUM  = 4'd4;
  localparam logic [RF_AW-1:0] R_KEY  = 4'd5;
  localparam logic [RF_AW-1:0] R_CELL = 4'd6;
  localparam logic [RF_AW-1:0] R_T    = 4'd7;
  localparam logic [RF_AW-1:0] R_A    = 4'd8;
  localparam logic [RF_AW-1:0] R_B    = 4'd9;
  localparam logic [RF_AW-1:0] R_U    = 4'd10;
  localparam logic [RF_AW-1:0] R_V    = 4'd11;
  localparam logic [RF_AW-1:0] R_N00  = 4'd12;
  localparam logic [RF_AW-1:0] R_N10  = 4'd13;
  localparam logic [RF_AW-1:0] R_N01  = 4'd14;
  localparam logic [RF_AW-1:0] R_N11  = 4'd15;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_WORLD, OP_CONST, OP_SCALE, OP_MULQ, OP_MULQS, OP_MULLO, OP_ADD, OP_SUB,
    OP_XS30, OP_XS27, OP_XS31, OP_TOP24, OP_SALTKEY, OP_CELL, OP_CORNIN,
    OP_FRAC, OP_ACCSH, OP_DBLSAT
  } op_e;

  // Constant operands
  typedef enum logic [3:0] {
    K_ZERO, K_GOLD, K_M1, K_M2, K_SIX, K_Q15, K_Q10, K_ROTC, K_ROTS
  } k_e;

  typedef struct packed {
    op_e              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
    logic             bk;
    k_e               k;
    logic [1:0]       imm;
  } uop_t;

  // Micro-program layout
  localparam int PC_W         = 7;
  localparam logic [PC_W-1:0] PC_INIT      = 7'd0;
  localparam logic [PC_W-1:0] PC_INIT_END  = 7'd2;
  localparam logic [PC_W-1:0] PC_LAYER     = 7'd3;
  localparam logic [PC_W-1:0] PC_LAYER_END = 7'd5;
  localparam logic [PC_W-1:0] PC_OCT       = 7'd6;
  localparam logic [PC_W-1:0] PC_OCT_END   = 7'd75;

  typedef struct packed {
    logic             cap;
    logic             rd;
    logic             ex;
    logic             wb;
    logic             div_start;
    logic             out_load;
    uop_t             uop;
    logic [CFG_W-1:0] layer;
    logic [OCT_W-1:0] oct;
    logic [CFG_W-1:0] layers;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } dp_sts_t;

  function automatic logic [63:0] kval(k_e k);
    logic [63:0] v;
    unique case (k)
      K_ZERO:  v = 64'd0;
      K_GOLD:  v = 64'h9E3779B97F4A7C15;
      K_M1:    v = 64'hBF58476D1CE4E5B9;
      K_M2:    v = 64'h94D049BB133111EB;
      K_SIX:   v = 64'd6;
      K_Q15:   v = QONE * 64'd15;
      K_Q10:   v = QONE * 64'd10;
      K_ROTC:  v = ROT_C;
      K_ROTS:  v = ROT_S;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_mul(op_e op);
    return (op == OP_MULQ) || (op == OP_MULQS) || (op == OP_MULLO);
  endfunction

  function automatic uop_t mk(op_e op, logic [RF_AW-1:0] dst, logic [RF_AW-1:0] ra,
                              logic [RF_AW-1:0] rb, logic bk, k_e k, logic [1:0] imm);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.ra  = ra;
    u.rb  = rb;
    u.bk  = bk;
    u.k   = k;
    u.imm = imm;
    return u;
  endfunction

  // Micro-program: init, per-layer prologue, per-octave body
  function automatic uop_t prog(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // init
      7'd0:  u = mk(OP_WORLD,   R_BX,   R_BX,   R_BX,  1'b0, K_ZERO, 2'd0);
      7'd1:  u = mk(OP_WORLD,   R_BY,   R_BY,   R_BY,  1'b0, K_ZERO, 2'd1);
      7'd2:  u = mk(OP_CONST,   R_SUM,  R_SUM,  R_SUM, 1'b1, K_ZERO, 2'd0);
      // layer prologue
      7'd3:  u = mk(OP_SCALE,   R_T,    R_T,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd4:  u = mk(OP_MULQS,   R_X,    R_BX,   R_T,   1'b0, K_ZERO, 2'd0);
      7'd5:  u = mk(OP_MULQS,   R_Y,    R_BY,   R_T,   1'b0, K_ZERO, 2'd0);
      // octave key
      7'd6:  u = mk(OP_SALTKEY, R_KEY,  R_KEY,  R_KEY, 1'b0, K_ZERO, 2'd0);
      7'd7:  u = mk(OP_ADD,     R_KEY,  R_KEY,  R_KEY, 1'b1, K_GOLD, 2'd0);
      7'd8:  u = mk(OP_XS30,    R_KEY,  R_KEY,  R_KEY, 1'b0, K_ZERO, 2'd0);
      7'd9:  u = mk(OP_MULLO,   R_KEY,  R_KEY,  R_KEY, 1'b1, K_M1,   2'd0);
      7'd10: u = mk(OP_XS27,    R_KEY,  R_KEY,  R_KEY, 1'b0, K_ZERO, 2'd0);
      7'd11: u = mk(OP_MULLO,   R_KEY,  R_KEY,  R_KEY, 1'b1, K_M2,   2'd0);
      7'd12: u = mk(OP_XS31,    R_KEY,  R_KEY,  R_KEY, 1'b0, K_ZERO, 2'd0);
      7'd13: u = mk(OP_CELL,    R_CELL, R_X,    R_Y,   1'b0, K_ZERO, 2'd0);
      // corner 00
      7'd14: u = mk(OP_CORNIN,  R_N00,  R_CELL, R_KEY, 1'b0, K_ZERO, 2'd0);
      7'd15: u = mk(OP_ADD,     R_N00,  R_N00,  R_N00, 1'b1, K_GOLD, 2'd0);
      7'd16: u = mk(OP_XS30,    R_N00,  R_N00,  R_N00, 1'b0, K_ZERO, 2'd0);
      7'd17: u = mk(OP_MULLO,   R_N00,  R_N00,  R_N00, 1'b1, K_M1,   2'd0);
      7'd18: u = mk(OP_XS27,    R_N00,  R_N00,  R_N00, 1'b0, K_ZERO, 2'd0);
      7'd19: u = mk(OP_MULLO,   R_N00,  R_N00,  R_N00, 1'b1, K_M2,   2'd0);
      7'd20: u = mk(OP_TOP24,   R_N00,  R_N00,  R_N00, 1'b0, K_ZERO, 2'd0);
      // corner 10
      7'd21: u = mk(OP_CORNIN,  R_N10,  R_CELL, R_KEY, 1'b0, K_ZERO, 2'd1);
      7'd22: u = mk(OP_ADD,     R_N10,  R_N10,  R_N10, 1'b1, K_GOLD, 2'd0);
      7'd23: u = mk(OP_XS30,    R_N10,  R_N10,  R_N10, 1'b0, K_ZERO, 2'd0);
      7'd24: u = mk(OP_MULLO,   R_N10,  R_N10,  R_N10, 1'b1, K_M1,   2'd0);
      7'd25: u = mk(OP_XS27,    R_N10,  R_N10,  R_N10, 1'b0, K_ZERO, 2'd0);
      7'd26: u = mk(OP_MULLO,   R_N10,  R_N10,  R_N10, 1'b1, K_M2,   2'd0);
      7'd27: u = mk(OP_TOP24,   R_N10,  R_N10,  R_N10, 1'b0, K_ZERO, 2'd0);
      // corner 01
      7'd28: u = mk(OP_CORNIN,  R_N01,  R_CELL, R_KEY, 1'b0, K_ZERO, 2'd2);
      7'd29: u = mk(OP_ADD,     R_N01,  R_N01,  R_N01, 1'b1, K_GOLD, 2'd0);
      7'd30: u = mk(OP_XS30,    R_N01,  R_N01,  R_N01, 1'b0, K_ZERO, 2'd0);
      7'd31: u = mk(OP_MULLO,   R_N01,  R_N01,  R_N01, 1'b1, K_M1,   2'd0);
      7'd32: u = mk(OP_XS27,    R_N01,  R_N01,  R_N01, 1'b0, K_ZERO, 2'd0);
      7'd33: u = mk(OP_MULLO,   R_N01,  R_N01,  R_N01, 1'b1, K_M2,   2'd0);
      7'd34: u = mk(OP_TOP24,   R_N01,  R_N01,  R_N01, 1'b0, K_ZERO, 2'd0);
      // corner 11
      7'd35: u = mk(OP_CORNIN,  R_N11,  R_CELL, R_KEY, 1'b0, K_ZERO, 2'd3);
      7'd36: u = mk(OP_ADD,     R_N11,  R_N11,  R_N11, 1'b1, K_GOLD, 2'd0);
      7'd37: u = mk(OP_XS30,    R_N11,  R_N11,  R_N11, 1'b0, K_ZERO, 2'd0);
      7'd38: u = mk(OP_MULLO,   R_N11,  R_N11,  R_N11, 1'b1, K_M1,   2'd0);
      7'd39: u = mk(OP_XS27,    R_N11,  R_N11,  R_N11, 1'b0, K_ZERO, 2'd0);
      7'd40: u = mk(OP_MULLO,   R_N11,  R_N11,  R_N11, 1'b1, K_M2,   2'd0);
      7'd41: u = mk(OP_TOP24,   R_N11,  R_N11,  R_N11, 1'b0, K_ZERO, 2'd0);
      // fade in x
      7'd42: u = mk(OP_FRAC,    R_T,    R_X,    R_X,   1'b0, K_ZERO, 2'd0);
      7'd43: u = mk(OP_MULLO,   R_A,    R_T,    R_T,   1'b1, K_SIX,  2'd0);
      7'd44: u = mk(OP_SUB,     R_A,    R_A,    R_A,   1'b1, K_Q15,  2'd0);
      7'd45: u = mk(OP_MULQ,    R_A,    R_T,    R_A,   1'b0, K_ZERO, 2'd0);
      7'd46: u = mk(OP_ADD,     R_A,    R_A,    R_A,   1'b1, K_Q10,  2'd0);
      7'd47: u = mk(OP_MULQ,    R_B,    R_T,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd48: u = mk(OP_MULQ,    R_B,    R_B,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd49: u = mk(OP_MULQ,    R_U,    R_B,    R_A,   1'b0, K_ZERO, 2'd0);
      // fade in y
      7'd50: u = mk(OP_FRAC,    R_T,    R_Y,    R_Y,   1'b0, K_ZERO, 2'd0);
      7'd51: u = mk(OP_MULLO,   R_A,    R_T,    R_T,   1'b1, K_SIX,  2'd0);
      7'd52: u = mk(OP_SUB,     R_A,    R_A,    R_A,   1'b1, K_Q15,  2'd0);
      7'd53: u = mk(OP_MULQ,    R_A,    R_T,    R_A,   1'b0, K_ZERO, 2'd0);
      7'd54: u = mk(OP_ADD,     R_A,    R_A,    R_A,   1'b1, K_Q10,  2'd0);
      7'd55: u = mk(OP_MULQ,    R_B,    R_T,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd56: u = mk(OP_MULQ,    R_B,    R_B,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd57: u = mk(OP_MULQ,    R_V,    R_B,    R_A,   1'b0, K_ZERO, 2'd0);
      // bilinear blend
      7'd58: u = mk(OP_SUB,     R_T,    R_N10,  R_N00, 1'b0, K_ZERO, 2'd0);
      7'd59: u = mk(OP_MULQ,    R_T,    R_U,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd60: u = mk(OP_ADD,     R_N00,  R_N00,  R_T,   1'b0, K_ZERO, 2'd0);
      7'd61: u = mk(OP_SUB,     R_T,    R_N11,  R_N01, 1'b0, K_ZERO, 2'd0);
      7'd62: u = mk(OP_MULQ,    R_T,    R_U,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd63: u = mk(OP_ADD,     R_N01,  R_N01,  R_T,   1'b0, K_ZERO, 2'd0);
      7'd64: u = mk(OP_SUB,     R_T,    R_N01,  R_N00, 1'b0, K_ZERO, 2'd0);
      7'd65: u = mk(OP_MULQ,    R_T,    R_V,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd66: u = mk(OP_ADD,     R_N00,  R_N00,  R_T,   1'b0, K_ZERO, 2'd0);
      7'd67: u = mk(OP_ACCSH,   R_SUM,  R_SUM,  R_N00, 1'b0, K_ZERO, 2'd0);
      // rotate and double
      7'd68: u = mk(OP_MULQ,    R_A,    R_X,    R_X,   1'b1, K_ROTC, 2'd0);
      7'd69: u = mk(OP_MULQ,    R_B,    R_Y,    R_Y,   1'b1, K_ROTS, 2'd0);
      7'd70: u = mk(OP_SUB,     R_A,    R_A,    R_B,   1'b0, K_ZERO, 2'd0);
      7'd71: u = mk(OP_MULQ,    R_B,    R_X,    R_X,   1'b1, K_ROTS, 2'd0);
      7'd72: u = mk(OP_MULQ,    R_T,    R_Y,    R_Y,   1'b1, K_ROTC, 2'd0);
      7'd73: u = mk(OP_ADD,     R_B,    R_B,    R_T,   1'b0, K_ZERO, 2'd0);
      7'd74: u = mk(OP_DBLSAT,  R_X,    R_A,    R_A,   1'b0, K_ZERO, 2'd0);
      7'd75: u = mk(OP_DBLSAT,  R_Y,    R_B,    R_B,   1'b0, K_ZERO, 2'd0);
      default: u = mk(OP_CONST, R_T,    R_T,    R_T,   1'b1, K_ZERO, 2'd0);
    endcase
    return u;
  endfunction

endpackage

@@ design/vnf_in_if.sv @@
// Input channel: seed and world coordinate beats.
`timescale 1ns / 1ps
interface vnf_in_if;
  logic                             valid;
  logic                             ready;
  logic [vnf_pkg::SEED_W-1:0]       seed;
  logic signed [vnf_pkg::WORLD_W-1:0] world_x;
  logic signed [vnf_pkg::WORLD_W-1:0] world_y;

  modport source (output valid, output seed, output world_x, output world_y, input ready);
  modport sink   (input valid, input seed, input world_x, input world_y, output ready);
endinterface

@@ design/vnf_out_if.sv @@
// Output channel: height beats.
`timescale 1ns / 1ps
interface vnf_out_if;
  logic                         valid;
  logic                         ready;
  logic [vnf_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

@@ design/vnf_mul.sv @@
// Sequential 64x64 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module vnf_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic         done_q;
  logic [31:0]  a_half, b_half;
  logic [127:0] pp_sh;

  // Pick the halves for this step
  assign a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = step_q[0] ? b_q[63:32] : b_q[31:0];

  // Align the previous partial product
  always_comb begin
    unique case (sh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd2:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = {32'd0, pp_q, 32'd0};
    endcase
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= busy_q && (step_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  // Multiply one step, accumulate the step before
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= a_half * b_half;
        sh_q <= {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};
      end
      if (step_q != 3'd0) acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ design/vnf_datapath.sv @@
// Datapath: register file, ALU, multiplier, divider and result register.
`timescale 1ns / 1ps
module vnf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vnf_pkg::dp_cmd_t               cmd_i,
  output vnf_pkg::dp_sts_t               sts_o,
  input  logic [vnf_pkg::SEED_W-1:0]     seed_i,
  input  logic [vnf_pkg::WORLD_W-1:0]    world_x_i,
  input  logic [vnf_pkg::WORLD_W-1:0]    world_y_i,
  output logic [vnf_pkg::HEIGHT_W-1:0]   height_o
);

  vnf_pkg::uop_t uop;
  logic [vnf_pkg::SEED_W-1:0]  seed_q;
  logic [vnf_pkg::WORLD_W-1:0] wx_q, wy_q;
  logic [63:0] rf_q [vnf_pkg::RF_N];
  logic [63:0] a_q, b_q, bval, alu_res, mul_res, wr_data, qres;
  logic [63:0] wsel, mul_a, mul_b;
  logic [31:0] salt;
  logic        wr_en, mul_start, mul_done, neg_q;
  logic [127:0] prod;
  logic [vnf_pkg::SUM_W-1:0]  sum_q;
  logic [vnf_pkg::DVD_W-1:0]  dvd_q;
  logic [vnf_pkg::DVS_W-1:0]  dvs_q;
  logic [vnf_pkg::DVS_W:0]    rem_q, rem_sh;
  logic [vnf_pkg::DCNT_W-1:0] cnt_q;
  logic [vnf_pkg::HEIGHT_W-1:0] height_q;
  logic [5:0]  acc_sh;

  function automatic logic [63:0] sat(logic [63:0] v);
    logic [63:0] r;
    if ($signed(v) > $signed(vnf_pkg::LIMIT)) r = vnf_pkg::LIMIT;
    else if ($signed(v) < -$signed(vnf_pkg::LIMIT)) r = 64'd0 - vnf_pkg::LIMIT;
    else r = v;
    return r;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  assign uop  = cmd_i.uop;
  assign bval = uop.bk ? vnf_pkg::kval(uop.k) : b_q;
  assign salt = vnf_pkg::SALT_BASE + 32'(cmd_i.layer) * vnf_pkg::SALT_STEP
              + 32'(cmd_i.oct);
  assign wsel = uop.imm[0] ? {{(64-vnf_pkg::WORLD_W){wy_q[vnf_pkg::WORLD_W-1]}}, wy_q}
                           : {{(64-vnf_pkg::WORLD_W){wx_q[vnf_pkg::WORLD_W-1]}}, wx_q};
  assign acc_sh = 6'(vnf_pkg::OCTAVES - 1) - 6'(cmd_i.oct);

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      seed_q <= seed_i;
      wx_q   <= world_x_i;
      wy_q   <= world_y_i;
    end
  end

  // Register file: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) rf_q[uop.dst] <= wr_data;
    if (cmd_i.rd) begin
      a_q <= rf_q[uop.ra];
      b_q <= rf_q[uop.rb];
    end
  end

  // Combinational ALU operations
  always_comb begin
    unique case (uop.op)
      vnf_pkg::OP_WORLD:   alu_res = sat(wsel << 10);
      vnf_pkg::OP_CONST:   alu_res = bval;
      vnf_pkg::OP_SCALE:   alu_res = vnf_pkg::QONE
                                   + 64'(cmd_i.layer) * vnf_pkg::SCALE_STEP;
      vnf_pkg::OP_ADD:     alu_res = a_q + bval;
      vnf_pkg::OP_SUB:     alu_res = a_q - bval;
      vnf_pkg::OP_XS30:    alu_res = a_q ^ (a_q >> 30);
      vnf_pkg::OP_XS27:    alu_res = a_q ^ (a_q >> 27);
      vnf_pkg::OP_XS31:    alu_res = a_q ^ (a_q >> 31);
      vnf_pkg::OP_TOP24:   alu_res = (a_q ^ (a_q >> 31)) >> 40;
      vnf_pkg::OP_SALTKEY: alu_res = {salt, seed_q};
      vnf_pkg::OP_CELL:    alu_res = {b_q[55:24], a_q[55:24]};
      vnf_pkg::OP_CORNIN:  alu_res = {a_q[63:32] + 32'(uop.imm[1]),
                                      a_q[31:0] + 32'(uop.imm[0])} ^ bval;
      vnf_pkg::OP_FRAC:    alu_res = {40'd0, a_q[23:0]};
      vnf_pkg::OP_ACCSH:   alu_res = a_q + (bval << acc_sh);
      vnf_pkg::OP_DBLSAT:  alu_res = sat(a_q << 1);
      default:             alu_res = 64'd0;
    endcase
  end

  // Multiplier operands: magnitudes for Q.24 products, raw operands for OP_MULLO
  assign mul_start = cmd_i.ex && vnf_pkg::is_mul(uop.op);
  assign mul_a = (uop.op == vnf_pkg::OP_MULLO) ? a_q : mag(a_q);
  assign mul_b = (uop.op == vnf_pkg::OP_MULLO) ? bval : mag(bval);

  always_ff @(posedge clk_i) begin
    if (mul_start) neg_q <= a_q[63] ^ bval[63];
  end

  vnf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Apply the sign, saturate where asked
  assign qres = neg_q ? 64'd0 - prod[87:24] : prod[87:24];
  always_comb begin
    unique case (uop.op)
      vnf_pkg::OP_MULLO: mul_res = prod[63:0];
      vnf_pkg::OP_MULQS: mul_res = sat(qres);
      default:           mul_res = qres;
    endcase
  end

  assign wr_en   = (cmd_i.ex && !vnf_pkg::is_mul(uop.op)) || cmd_i.wb;
  assign wr_data = cmd_i.wb ? mul_res : alu_res;

  // Shadow the running sum for the divider
  always_ff @(posedge clk_i) begin
    if (wr_en && (uop.dst == vnf_pkg::R_SUM)) sum_q <= wr_data[vnf_pkg::SUM_W-1:0];
  end

  // Restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_q[vnf_pkg::DVS_W-1:0], dvd_q[vnf_pkg::DVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= vnf_pkg::DCNT_W'(vnf_pkg::DVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - vnf_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= vnf_pkg::DVD_W'(sum_q) * vnf_pkg::DVD_W'(vnf_pkg::HSCALE);
      dvs_q <= (vnf_pkg::DVS_W'(cmd_i.layers) * vnf_pkg::DVS_W'(vnf_pkg::OCT_MASK)) << 8;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        dvd_q <= {dvd_q[vnf_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        dvd_q <= {dvd_q[vnf_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  // Hold the finished height
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) height_q <= dvd_q[vnf_pkg::HEIGHT_W-1:0];
  end

  assign height_o       = height_q;
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = (cnt_q == '0);

endmodule

@@ design/vnf_ctrl.sv @@
// Controller: layer register, micro-program sequencer and channel handshakes.
`timescale 1ns / 1ps
module vnf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        cfg_we_i,
  input  logic [vnf_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  vnf_pkg::dp_sts_t            sts_i,
  output vnf_pkg::dp_cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_MULW = 6'b001000,
    S_DIVS = 6'b010000,
    S_DIV  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [vnf_pkg::PC_W-1:0]  pc_q, pc_d;
  logic [vnf_pkg::OCT_W-1:0] oct_q, oct_d;
  logic [vnf_pkg::CFG_W-1:0] layer_q, layer_d;
  logic [vnf_pkg::CFG_W-1:0] layers_q;
  logic                      out_valid_q, out_valid_d;
  logic                      accept, step_done, out_load;
  vnf_pkg::uop_t             uop;

  assign uop       = vnf_pkg::prog(pc_q);
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign step_done = ((state_q == S_EXEC) && !vnf_pkg::is_mul(uop.op))
                  || ((state_q == S_MULW) && sts_i.mul_done);
  assign out_load  = (state_q == S_DIV) && sts_i.div_done && !out_valid_q;

  // Layer count register, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layers_q <= vnf_pkg::CFG_W'(vnf_pkg::LAYERS_RST);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) layers_q <= vnf_pkg::CFG_W'(1);
      else if (32'(cfg_wdata_i) > vnf_pkg::MAX_LAYERS)
        layers_q <= vnf_pkg::CFG_W'(vnf_pkg::MAX_LAYERS);
      else layers_q <= cfg_wdata_i;
    end
  end

  // Sequence the program and the loops
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    oct_d       = oct_q;
    layer_d     = layer_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pc_d    = vnf_pkg::PC_INIT;
          oct_d   = '0;
          layer_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC, S_MULW: begin
        if (vnf_pkg::is_mul(uop.op) && (state_q == S_EXEC)) state_d = S_MULW;
        if (step_done) begin
          state_d = S_READ;
          if (pc_q == vnf_pkg::PC_INIT_END) begin
            pc_d = vnf_pkg::PC_LAYER;
          end else if (pc_q == vnf_pkg::PC_LAYER_END) begin
            pc_d = vnf_pkg::PC_OCT;
          end else if (pc_q == vnf_pkg::PC_OCT_END) begin
            if (oct_q != vnf_pkg::OCT_W'(vnf_pkg::OCTAVES - 1)) begin
              oct_d = oct_q + vnf_pkg::OCT_W'(1);
              pc_d  = vnf_pkg::PC_OCT;
            end else if (layer_q != layers_q - vnf_pkg::CFG_W'(1)) begin
              oct_d   = '0;
              layer_d = layer_q + vnf_pkg::CFG_W'(1);
              pc_d    = vnf_pkg::PC_LAYER;
            end else begin
              state_d = S_DIVS;
            end
          end else begin
            pc_d = pc_q + vnf_pkg::PC_W'(1);
          end
        end
      end
      S_DIVS: state_d = S_DIV;
      S_DIV: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      oct_q       <= '0;
      layer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      oct_q       <= oct_d;
      layer_q     <= layer_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Drive the datapath commands
  always_comb begin
    cmd_o.cap       = accept;
    cmd_o.rd        = (state_q == S_READ);
    cmd_o.ex        = (state_q == S_EXEC);
    cmd_o.wb        = (state_q == S_MULW) && sts_i.mul_done;
    cmd_o.div_start = (state_q == S_DIVS);
    cmd_o.out_load  = out_load;
    cmd_o.uop       = uop;
    cmd_o.layer     = layer_q;
    cmd_o.oct       = oct_q;
    cmd_o.layers    = layers_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/value_noise_fbm_sampler_unit.sv @@
// Top level of the fractal value noise sampler.
//
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      seed[31:0], world_x[47:0], world_y[47:0]
//  out_o    out  valid/ready      height[24:0]
//  cfg      in   cfg_we_i         cfg_wdata_i[4:0] = layer_count
//
// One item at a time. An ALU step is a read and an execute; a multiply on the
// shared 64-bit multiplier is a read, an execute, four 32x32 partial products, a
// final add and a write back. An octave is 70 steps (27 multiplies); a layer is four
// octaves plus a prologue that sets the layer scale and scales x and y. An item
// runs the init, layer_count layers and then the 42-bit divider.
// Reset clears the sequencer and sets layer_count to 4; no memory clearing pass.
// A finished height waits in the output register; the next beat may be taken then.
`timescale 1ns / 1ps
module value_noise_fbm_sampler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  vnf_in_if.sink                    in_i,
  vnf_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [vnf_pkg::CFG_W-1:0] cfg_wdata_i
);

  vnf_pkg::dp_cmd_t cmd;
  vnf_pkg::dp_sts_t sts;

  vnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vnf_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .seed_i    (in_i.seed),
    .world_x_i (in_i.world_x),
    .world_y_i (in_i.world_y),
    .height_o  (out_o.height)
  );

endmodule
